FILE: sv/abs_tape_pkg.sv
// Package for the absolute tape block parser.
// Holds the parse phase type, event codes and header constants.
// No dependencies.
`default_nettype none

package abs_tape_pkg;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_GOT_SOH  = 3'd1,
        PH_CNT_LO   = 3'd2,
        PH_CNT_HI   = 3'd3,
        PH_ADDR_LO  = 3'd4,
        PH_ADDR_HI  = 3'd5,
        PH_DATA     = 3'd6,
        PH_CSUM     = 3'd7
    } phase_t;

    typedef logic [2:0] event_t;

    localparam event_t EV_NONE    = 3'd0;
    localparam event_t EV_WRITE   = 3'd1;
    localparam event_t EV_ENTRY   = 3'd2;
    localparam event_t EV_OK      = 3'd3;
    localparam event_t EV_CSUM    = 3'd4;
    localparam event_t EV_BADSIZE = 3'd5;

    localparam logic [7:0]  HDR_START = 8'h01;
    localparam logic [15:0] HDR_SIZE  = 16'd6;

endpackage

`default_nettype wire

FILE: sv/absolute_tape_block_parser.sv
// Absolute tape block parser, top level.
// Depends on abs_tape_pkg for phase type, event codes and header constants.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  input    | in_valid / in_stall    | tape_byte[7:0]
//  output   | out_valid / out_stall  | event_res[2:0] address[15:0] data[7:0]
//
// One tape byte per cycle while in_stall is low: each byte gives exactly one
// result in the cycle after it is taken. A single phase/sum update lies between the
// parser state registers and the result register.
// Reset clears the phase, counters and the result valid flag.
// A stalled result holds; a new byte is still taken in the cycle the result
// leaves, so in_stall is high only while a held result is stalled.
`default_nettype none

module absolute_tape_block_parser
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            tape_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output abs_tape_pkg::event_t       event_res,
    output logic [15:0]                address,
    output logic [7:0]                 data
);
    import abs_tape_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [7:0]   sum_reg, sum_next;
    logic [15:0]  pos_reg, pos_next;
    logic [15:0]  len_reg, len_next;
    logic [15:0]  addr_reg, addr_next;

    logic         out_valid_reg;
    event_t       ev_reg, ev_next;
    logic [15:0]  res_addr_reg, res_addr_next;
    logic [7:0]   res_data_reg, res_data_next;

    logic         accept;
    logic [7:0]   sum_add;
    logic [15:0]  pos_inc;
    logic [15:0]  addr_hi;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign event_res = ev_reg;
    assign address   = res_addr_reg;
    assign data      = res_data_reg;

    assign sum_add = sum_reg + tape_byte;
    assign pos_inc = pos_reg + 16'd1;
    assign addr_hi = {tape_byte, addr_reg[7:0]};

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        addr_next     = addr_reg;
        ev_next       = EV_NONE;
        res_addr_next = 16'd0;
        res_data_next = 8'd0;
        case (phase_reg)
            PH_HUNT:
            begin
                sum_next = 8'd0;
                if (tape_byte == HDR_START)
                begin
                    phase_next = PH_GOT_SOH;
                    pos_next   = 16'd1;
                    sum_next   = tape_byte;
                end
            end
            PH_GOT_SOH:
            begin
                // a broken header drops back to hunting without rescanning this byte
                if (tape_byte != 8'd0)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_CNT_LO;
                    pos_next   = pos_inc;
                    sum_next   = sum_add;
                end
            end
            PH_CNT_LO:
            begin
                len_next   = {8'd0, tape_byte};
                sum_next   = sum_add;
                pos_next   = pos_inc;
                phase_next = PH_CNT_HI;
            end
            PH_CNT_HI:
            begin
                len_next   = {tape_byte, len_reg[7:0]};
                sum_next   = sum_add;
                pos_next   = pos_inc;
                phase_next = PH_ADDR_LO;
            end
            PH_ADDR_LO:
            begin
                addr_next  = {8'd0, tape_byte};
                sum_next   = sum_add;
                pos_next   = pos_inc;
                phase_next = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                addr_next = addr_hi;
                sum_next  = sum_add;
                pos_next  = pos_inc;
                if (pos_inc > len_reg)
                begin
                    ev_next       = EV_BADSIZE;
                    res_addr_next = addr_hi;
                    phase_next    = PH_HUNT;
                end
                else if (len_reg == HDR_SIZE)
                begin
                    ev_next       = EV_ENTRY;
                    res_addr_next = addr_hi;
                    phase_next    = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                ev_next       = EV_WRITE;
                res_addr_next = addr_reg;
                res_data_next = tape_byte;
                sum_next      = sum_add;
                addr_next     = addr_reg + 16'd1;
                pos_next      = pos_inc;
                if (pos_inc >= len_reg)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                if (sum_add != 8'd0)
                begin
                    ev_next       = EV_CSUM;
                    res_data_next = sum_add;
                end
                else
                begin
                    ev_next = EV_OK;
                end
                sum_next   = 8'd0;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= 8'd0;
            pos_reg       <= 16'd0;
            len_reg       <= 16'd0;
            addr_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                addr_reg  <= addr_next;
            end
            // drop the valid flag once the result is taken and nothing new came in
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg       <= ev_next;
            res_addr_reg <= res_addr_next;
            res_data_reg <= res_data_next;
        end
    end

    a_data_gives_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_DATA |=> event_res == EV_WRITE)
        else $error("data byte did not give a byte write");

    a_csum_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_CSUM |=> phase_reg == PH_HUNT && sum_reg == 8'd0)
        else $error("checksum byte did not return to hunting with a clear sum");

    a_hunt_stays: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_HUNT && tape_byte != HDR_START |=> phase_reg == PH_HUNT)
        else $error("left hunting without a header start byte");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_BADSIZE)
        else $error("event code out of range");

    a_held_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result was lost");

endmodule

`default_nettype wire
